FILE: src/byte_level_utf8_unmap_top_assert.svh
// Assertion macros used by the RTL of the byte-level unmap block.
// BLUU_ASSERT_IMPL checks a consequent in the same cycle as its antecedent.
// BLUU_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef BYTE_LEVEL_UTF8_UNMAP_TOP_ASSERT_SVH
`define BYTE_LEVEL_UTF8_UNMAP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BLUU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bluu assertion failed");
`define BLUU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bluu assertion failed");
`else
`define BLUU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BLUU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/bluu_pkg.sv
`timescale 1ns / 1ps
package bluu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Printable byte ranges that map to themselves.
   localparam logic [7:0] PRINT_LO1 = 8'h21;
   localparam logic [7:0] PRINT_HI1 = 8'h7E;
   localparam logic [7:0] PRINT_LO2 = 8'hA1;
   localparam logic [7:0] PRINT_HI2 = 8'hAC;
   localparam logic [7:0] PRINT_LO3 = 8'hAE;

   // Shifted codepoints start at 256 and end at 323.
   localparam logic [20:0] SHIFT_CP_MAX  = 21'd323;
   localparam logic [6:0]  SHIFT_RUN1    = 7'd33;
   localparam logic [6:0]  SHIFT_RUN2    = 7'd67;
   localparam logic [7:0]  SHIFT_OFFSET2 = 8'h5E;
   localparam logic [7:0]  SOFT_HYPHEN   = 8'hAD;

   // Sequence length minus one.
   typedef enum logic [1:0] {
      LEN_1 = 2'd0,
      LEN_2 = 2'd1,
      LEN_3 = 2'd2,
      LEN_4 = 2'd3
   } len_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // One decoded sequence: the bytes to send and the index of the last one.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qport_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] raw;
   } unmap_type;

   function automatic len_type seq_len(logic [7:0] lead);
      len_type r;
      if (lead[7] == 1'b0) begin
         r = LEN_1;
      end else if (lead[7:5] == 3'b110) begin
         r = LEN_2;
      end else if (lead[7:4] == 4'b1110) begin
         r = LEN_3;
      end else begin
         r = LEN_4;
      end
      return r;
   endfunction

   function automatic logic is_printable(logic [7:0] b);
      return ((b >= PRINT_LO1) && (b <= PRINT_HI1)) ||
             ((b >= PRINT_LO2) && (b <= PRINT_HI2)) ||
             (b >= PRINT_LO3);
   endfunction

   // Inverse of the byte-to-unicode table.
   function automatic unmap_type unmap_cp(logic [20:0] cp);
      unmap_type r;
      logic [6:0] n;
      n     = cp[6:0];
      r.hit = 1'b0;
      r.raw = cp[7:0];
      if (cp[20:8] == 13'd0) begin
         r.hit = is_printable(cp[7:0]);
      end else if (cp <= SHIFT_CP_MAX) begin
         r.hit = 1'b1;
         if (n < SHIFT_RUN1) begin
            r.raw = {1'b0, n};
         end else if (n < SHIFT_RUN2) begin
            r.raw = {1'b0, n} + SHIFT_OFFSET2;
         end else begin
            r.raw = SOFT_HYPHEN;
         end
      end
      return r;
   endfunction

endpackage

FILE: src/byte_level_utf8_unmap_top.sv
`timescale 1ns / 1ps
// Byte-level vocabulary string decoder. Each request carries one byte of a
// mapped UTF-8 string in in_byte, with in_last set on the string's final byte.
// The lead byte of a sequence fixes its length, from one to four bytes. When a
// sequence is complete its codepoint is looked up in the inverse byte-to-unicode
// table: a hit yields one raw byte, a miss yields the sequence's original bytes.
// Each completed sequence produces one to four results on the rsp_ channel, and
// out_last marks the final result of the request that completed it. Requests
// that only extend a sequence produce nothing, and a sequence cut short by
// in_last is dropped.
// The first result of a completing request passes the queue and the back end's
// current entry and output registers. One request is taken and one result
// leaves per cycle, each while its stall is low; the single output register of
// the back end sets the result rate. req_stall rises while the queue between
// the front and back ends is full. rsp_stall holds the current result steady;
// the front keeps accepting until the queue fills. Reset clears the partial
// sequence, the queue and the output.
module byte_level_utf8_unmap_top
   import bluu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Decoded sequences flow from the front end into the queue.
   qport_type push;
   // The head of the queue is offered to the back end, which pops it.
   qport_type head;
   logic      q_full;
   logic      pop;

   // The front end assembles sequences and performs the table lookup.
   bluu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   // The short queue lets the front keep accepting while results drain.
   bluu_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // The back end sends each sequence's bytes out one result per cycle while rsp_stall is low.
   bluu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/bluu_front.sv
`timescale 1ns / 1ps
module bluu_front
   import bluu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      q_full,
   output qport_type push
);

   logic [7:0]      held_ff [3];
   logic [1:0]      count_ff;
   logic [1:0]      count_in;
   logic            accept;
   logic [3:0][7:0] seq;
   len_type         len;
   logic            complete;
   logic [20:0]     cp;
   unmap_type       look;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Held bytes first, the new byte in the next free slot.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         seq[k] = (2'(k) < count_ff) ? held_ff[k] : req_data.in_byte;
      end
      seq[3] = req_data.in_byte;
   end

   assign len      = seq_len(seq[0]);
   assign complete = (count_ff == len);

   always_comb begin
      unique case (len)
         LEN_1:   cp = {13'd0, seq[0]};
         LEN_2:   cp = {10'd0, seq[0][4:0], seq[1][5:0]};
         LEN_3:   cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
         LEN_4:   cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
         default: cp = '0;
      endcase
   end

   assign look = unmap_cp(cp);

   always_comb begin
      push.valid = accept && complete;
      if (look.hit) begin
         push.entry.data     = {24'd0, look.raw};
         push.entry.last_idx = 2'd0;
      end else begin
         push.entry.data     = seq;
         push.entry.last_idx = len;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = complete ? 2'd0 : count_ff + 2'd1;
         if (req_data.in_last) begin
            count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !complete && (count_ff != 2'd3)) begin
         held_ff[count_ff] <= req_data.in_byte;
      end
   end

endmodule

FILE: src/bluu_queue.sv
`timescale 1ns / 1ps
`include "byte_level_utf8_unmap_top_assert.svh"
module bluu_queue
   import bluu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  qport_type push,
   output logic      full,
   output qport_type head,
   input  logic      pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign full       = (cnt_ff == CNT_FULL);
   assign head.valid = (cnt_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `BLUU_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_FULL)
   `BLUU_ASSERT_IMPL(a_no_push_full, clock, reset, push.valid, !full)
   `BLUU_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, head.valid)
   `BLUU_ASSERT_NEXT(a_pop_drains, clock, reset, do_pop && !do_push, cnt_ff == $past(cnt_ff) - 1'b1)

endmodule

FILE: src/bluu_back.sv
`timescale 1ns / 1ps
module bluu_back
   import bluu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qport_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic      cur_valid_ff;
   entry_type cur_ff;
   logic [1:0] idx_ff;
   logic      out_valid_ff;
   rsp_type   out_ff;
   logic      out_free;
   logic      emit;
   logic      cur_done;
   logic      cur_load;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;
   assign cur_done = emit && (idx_ff == cur_ff.last_idx);
   assign cur_load = head.valid && (!cur_valid_ff || cur_done);
   assign pop      = cur_load;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (cur_load) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_free) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cur_load) begin
         cur_ff <= head.entry;
      end
      if (emit) begin
         out_ff.out_byte <= cur_ff.data[idx_ff];
         out_ff.out_last <= (idx_ff == cur_ff.last_idx);
      end
   end

endmodule

FILE: tb/sv/tb_byte_level_utf8_unmap_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the byte-level vocabulary string decoder.
// Each accepted request goes through a behavioral decoder in this bench, and
// that decoder queues the bytes the block must produce. A checker compares
// every accepted result with the oldest queued byte.
module tb_byte_level_utf8_unmap_top;
   import bluu_pkg::*;

   // Kinds of random sequence. Plain ASCII is weighted up in the picker below.
   typedef enum int {
      SEQ_ASCII,
      SEQ_SHIFTED,
      SEQ_TWO_BYTE,
      SEQ_THREE_BYTE,
      SEQ_FOUR_BYTE,
      SEQ_HIGH_PRINTABLE,
      SEQ_NOISE
   } seq_kind_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Bytes that the decoder in this bench says must come out, oldest first.
   rsp_type    expected_bytes[$];
   rsp_type    oldest_expected;
   int         failures;

   // Our own copy of the partial sequence that the block holds.
   logic [7:0] pending_bytes[3];
   int         pending_count;

   // Idle and stall rates, in percent, for the current phase.
   int         send_idle_pct;
   int         rsp_stall_pct;

   // Bytes of the string that the random test is building.
   logic [7:0] string_bytes[$];

   byte_level_utf8_unmap_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run cannot take anywhere near this long, even with every phase at its
   // slowest, so reaching it means the block has hung.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // Decodes one accepted request the way the block must, and queues the
   // results it causes. A completed sequence whose codepoint is in the inverse
   // table gives one raw byte. Any other codepoint, overlong forms included,
   // sends the original bytes back unchanged. A string end that arrives before
   // the sequence is complete drops the held bytes with no result.
   function automatic void predict_unmap(input req_type item);
      logic [7:0] seq[4];
      int         held_n;
      int         len;
      int         cp;
      int         k;
      int         shift_idx;
      logic       hit;
      logic [7:0] raw;
      rsp_type    res;
      held_n = pending_count;
      for (k = 0; k < held_n; k++) begin
         seq[k] = pending_bytes[k];
      end
      seq[held_n] = item.in_byte;

      // The lead byte sets the length. Continuation bytes and 0xF8 and up
      // start a four-byte sequence when they come first.
      if (seq[0][7] == 1'b0) begin
         len = 1;
      end else if (seq[0][7:5] == 3'b110) begin
         len = 2;
      end else if (seq[0][7:4] == 4'b1110) begin
         len = 3;
      end else begin
         len = 4;
      end

      if (held_n + 1 >= len) begin
         case (len)
            1: cp = int'(seq[0]);
            2: cp = int'(seq[0][4:0]);
            3: cp = int'(seq[0][3:0]);
            default: cp = int'(seq[0][2:0]);
         endcase
         // Later bytes give their low six bits, whatever their top bits are.
         for (k = 1; k < len; k++) begin
            cp = (cp << 6) | int'(seq[k][5:0]);
         end

         hit = 1'b0;
         raw = 8'h00;
         if (cp < 256) begin
            hit = (cp >= 'h21 && cp <= 'h7E) || (cp >= 'hA1 && cp <= 'hAC) ||
                  (cp >= 'hAE);
            raw = cp[7:0];
         end else if (cp <= 323) begin
            // The 68 shifted bytes in ascending order: the controls and the
            // space, then 0x7F through 0xA0, then the soft hyphen.
            hit = 1'b1;
            shift_idx = cp - 256;
            if (shift_idx < 33) begin
               raw = shift_idx[7:0];
            end else if (shift_idx < 67) begin
               raw = 8'(8'h7F + shift_idx - 33);
            end else begin
               raw = 8'hAD;
            end
         end

         if (hit) begin
            res.out_byte = raw;
            res.out_last = 1'b1;
            expected_bytes = {expected_bytes, res};
         end else begin
            for (k = 0; k < len; k++) begin
               res.out_byte = seq[k];
               res.out_last = (k == len - 1);
               expected_bytes = {expected_bytes, res};
            end
         end
         pending_count = 0;
      end else begin
         pending_bytes[held_n] = item.in_byte;
         pending_count = held_n + 1;
      end

      if (item.in_last) begin
         pending_count = 0;
      end
   endfunction

   // Sends one request. It is called just after a rising edge, and it returns
   // just after the edge that accepted the request, so valid stays high across
   // back-to-back requests and never drops and rises in one time step.
   task automatic send_byte(input logic [7:0] value, input logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.in_byte <= value;
      req_data.in_last <= last;
      // Outputs are read here before this edge's updates land, so req_stall is
      // the value that the edge itself sees.
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_unmap('{in_byte: value, in_last: last});
   endtask

   // Stops sending until every queued result has come out, then gives the
   // pipeline time to settle.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // Appends one byte to the string being built.
   function automatic void add_string_byte(input logic [7:0] value);
      string_bytes = {string_bytes, value};
   endfunction

   // Continuation byte, usually well formed, now and then any byte at all.
   function automatic logic [7:0] cont_byte();
      if ($urandom_range(7) == 0) begin
         return 8'($urandom);
      end
      return {2'b10, 6'($urandom)};
   endfunction

   // Adds one sequence of random kind to the string being built.
   function automatic void append_random_sequence();
      seq_kind_type kind;
      int           pick;
      int           cp;
      pick = $urandom_range(9);
      if (pick > int'(SEQ_NOISE)) begin
         kind = SEQ_ASCII;
      end else begin
         kind = seq_kind_type'(pick);
      end
      case (kind)
         SEQ_ASCII: begin
            add_string_byte({1'b0, 7'($urandom)});
         end
         SEQ_SHIFTED: begin
            // Two-byte encoding of a codepoint in the shifted range.
            cp = $urandom_range(256, 323);
            add_string_byte(8'hC0 | 8'(cp >> 6));
            add_string_byte(8'h80 | 8'(cp & 'h3F));
         end
         SEQ_TWO_BYTE: begin
            add_string_byte({3'b110, 5'($urandom)});
            add_string_byte(cont_byte());
         end
         SEQ_THREE_BYTE: begin
            add_string_byte({4'b1110, 4'($urandom)});
            add_string_byte(cont_byte());
            add_string_byte(cont_byte());
         end
         SEQ_FOUR_BYTE: begin
            if ($urandom_range(1) == 1) begin
               add_string_byte(8'($urandom_range('hF0, 'hFF)));
            end else begin
               add_string_byte({2'b10, 6'($urandom)});
            end
            add_string_byte(cont_byte());
            add_string_byte(cont_byte());
            add_string_byte(cont_byte());
         end
         SEQ_HIGH_PRINTABLE: begin
            // Two-byte lead for the upper half of the byte range, with a random continuation byte.
            cp = $urandom_range(128, 255);
            add_string_byte(8'hC0 | 8'(cp >> 6));
            add_string_byte(cont_byte());
         end
         default: begin
            add_string_byte(8'($urandom));
         end
      endcase
   endfunction

   // Single-byte sequences at the edges of the printable ASCII range.
   task automatic test_single_byte_sequences();
      send_byte(8'h00, 1'b1);
      send_byte(8'h21, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // Two-byte sequences: both ends of the shifted range, the top printable
   // byte, the soft hyphen that is not in the table as itself, and the first
   // codepoint past the shifted range.
   task automatic test_two_byte_sequences();
      send_byte(8'hC4, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC5, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'hC2, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'hC5, 1'b0);
      send_byte(8'h84, 1'b1);
   endtask

   // A three-byte miss, an all-ones four-byte miss and a continuation byte
   // with no marker bits that still completes a hit.
   task automatic test_long_and_odd_sequences();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hC4, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // A sequence cut short by the string end is dropped, and the next string
   // starts clean.
   task automatic test_truncated_strings();
      send_byte(8'hC4, 1'b1);
      send_byte(8'h41, 1'b1);
   endtask

   // Random strings of one to four sequences, with the final byte sometimes
   // cut off so that the last sequence may be left incomplete.
   task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                      input int item_goal);
      int sent;
      int count;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_goal) begin
         string_bytes.delete();
         count = $urandom_range(1, 4);
         repeat (count) append_random_sequence();
         if (string_bytes.size() > 1 && $urandom_range(99) < 12) begin
            void'(string_bytes.pop_back());
         end
         foreach (string_bytes[i]) begin
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
         end
         sent += string_bytes.size();
      end
   endtask

   // The receiver stalls at the phase's rate. The stall is drawn fresh on
   // every edge, so it does not depend on what the block is presenting.
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Every accepted result must match the oldest queued byte.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("result with nothing expected: out_byte %h, out_last %b",
                   rsp_data.out_byte, rsp_data.out_last);
            failures++;
         end else begin
            oldest_expected = expected_bytes.pop_front();
            if (rsp_data.out_byte !== oldest_expected.out_byte) begin
               $error("out_byte: expected %h, actual %h",
                      oldest_expected.out_byte, rsp_data.out_byte);
               failures++;
            end
            if (rsp_data.out_last !== oldest_expected.out_last) begin
               $error("out_last: expected %b, actual %b",
                      oldest_expected.out_last, rsp_data.out_last);
               failures++;
            end
         end
      end
   end

   initial begin
      failures      = 0;
      pending_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_byte_sequences();
      test_two_byte_sequences();
      test_long_and_odd_sequences();
      test_truncated_strings();
      // The sender waits here until every result of the directed part is out.
      hold_until_drained();

      // Random phases: free running, a slow sender, a slow receiver, and both
      // slowed a little.
      test_random_strings(0, 0, 125);
      test_random_strings(79, 0, 125);
      hold_until_drained();
      test_random_strings(0, 79, 125);
      test_random_strings(25, 25, 125);

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected results never arrived", expected_bytes.size());
         failures++;
      end

      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
